// File: hw/rtl/sghq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sghq_pkg: shared types and constants for the ground height query block
// Action codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package sghq_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int GY_BITS    = 24;
  localparam int CNT_BITS   = 7;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_QUERY  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_READ,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_TEST,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } state_e;

endpackage

// File: hw/rtl/sghq_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sghq_req_if: request channel
// Valid/ready channel carrying one action and its operands.
// ----------------------------------------------------------------------------
interface sghq_req_if import sghq_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic signed [COORD_BITS-1:0] seg_x_left;
  logic signed [COORD_BITS-1:0] seg_y_left;
  logic signed [COORD_BITS-1:0] seg_x_right;
  logic signed [COORD_BITS-1:0] seg_y_right;
  logic signed [COORD_BITS-1:0] probe_x;
  logic signed [COORD_BITS-1:0] probe_y;

  modport source (output valid, action, seg_x_left, seg_y_left, seg_x_right,
                  seg_y_right, probe_x, probe_y, input ready);
  modport sink (input valid, action, seg_x_left, seg_y_left, seg_x_right,
                seg_y_right, probe_x, probe_y, output ready);
endinterface

// File: hw/rtl/sghq_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sghq_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface sghq_rsp_if import sghq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [GY_BITS-1:0] ground_y;
  logic                      table_full;
  logic [CNT_BITS-1:0]       segment_count;

  modport source (output valid, hit, ground_y, table_full, segment_count,
                  input ready);
  modport sink (input valid, hit, ground_y, table_full, segment_count,
                output ready);
endinterface

// File: hw/rtl/segment_ground_height_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_ground_height_query: segment table with vertical ray height query
// Add, delete, clear and query over a table of line segments, with one shared
// multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Sequencing: clear goes straight from idle to the response; add scans for a
//   free slot; delete and query scan every entry, and a query also runs the
//   multiply steps for every covering entry and a division for each covering
//   entry that passes the height test.
// Throughput: one request at a time, set by the entry scan through the single
//   memory read port and by the one-bit-per-cycle divider.
// Reset: asynchronous, active low; the table reads empty right after reset.
module segment_ground_height_query import sghq_pkg::*; #(
  parameter int MAX_SEGMENTS = 64
) (
  input logic clk_i,
  input logic rst_ni,
  sghq_req_if.sink   req_i,
  sghq_rsp_if.source rsp_o
);

  localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int DIF_W  = COORD_BITS + 1;        // coordinate differences
  localparam int PRD_W  = 2 * DIF_W;             // multiplier product
  localparam int NUM_W  = PRD_W + 1;             // interpolation numerator
  localparam int DIV_W  = NUM_W + FRAC_BITS;     // dividend / quotient
  localparam int VAL_W  = DIV_W + 1;             // signed candidate height
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int ENT_W  = 4 * COORD_BITS;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(MAX_SEGMENTS - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_W - 1);
  localparam logic signed [VAL_W-1:0] GY_MAX = VAL_W'((1 << (GY_BITS - 1)) - 1);
  localparam logic signed [VAL_W-1:0] GY_MIN = -VAL_W'(1 << (GY_BITS - 1));

  state_e state_q, state_d;

  // Captured request
  logic [1:0]                   act_q;
  logic signed [COORD_BITS-1:0] xl_q, yl_q, xr_q, yr_q, px_q, py_q;

  // Table
  logic [ENT_W-1:0]        mem_q [MAX_SEGMENTS];
  logic [ENT_W-1:0]        rd_q;
  logic [MAX_SEGMENTS-1:0] valid_q;
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        idx_q;

  // Arithmetic
  logic signed [DIF_W-1:0] dx_q, dy_q, t_q;
  logic signed [DIF_W-1:0] mul_a, mul_b;
  logic signed [PRD_W-1:0] prod, prod_q;
  logic signed [NUM_W-1:0] num_q;
  logic                    neg_q;
  logic [DIV_W-1:0]        dvd_q;
  logic [DIF_W-1:0]        rem_q;
  logic [DCNT_W-1:0]       dcnt_q;
  logic signed [VAL_W-1:0] best_q;
  logic                    found_q;
  logic                    full_q;

  // Response register
  logic                      out_valid_q;
  logic                      hit_q;
  logic signed [GY_BITS-1:0] gy_q;
  logic                      tfull_q;
  logic [CNT_BITS-1:0]       cnt_out_q;

  // Unpacked fields of the entry under test
  logic signed [COORD_BITS-1:0] e_xl, e_yl, e_xr, e_yr;
  assign {e_xl, e_yl, e_xr, e_yr} = rd_q;

  logic is_last, covers, matches_req, out_free, req_fire, step_div;
  logic [DIF_W:0]          rem_sh;
  logic [DIF_W:0]          rem_sub;
  logic signed [VAL_W-1:0] cand;
  logic signed [VAL_W-1:0] best_sat;
  logic [CNT_W+CNT_BITS-1:0] cnt_ext;
  logic [NUM_W-1:0]        num_mag;

  assign is_last  = (idx_q == LAST_IDX);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_fire = req_i.valid && req_i.ready;

  // Entry is usable for a query: occupied, not vertical, spans the probe x
  assign covers = valid_q[idx_q] && (e_xl != e_xr) && (px_q >= e_xl) &&
                  (px_q <= e_xr);
  assign matches_req = valid_q[idx_q] && (rd_q == {xl_q, yl_q, xr_q, yr_q});

  // Shared multiplier: operands picked by the sequencer step
  always_comb begin
    case (state_q)
      ST_MUL_A: begin
        mul_a = DIF_W'(e_yl);
        mul_b = dx_q;
      end
      ST_MUL_B: begin
        mul_a = dy_q;
        mul_b = t_q;
      end
      default: begin
        mul_a = DIF_W'(py_q);
        mul_b = dx_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Restoring divider step: shift in one dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dx_q};
  assign step_div = (rem_sh >= {1'b0, dx_q});

  assign cand    = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
  assign num_mag = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);

  assign best_sat = (best_q > GY_MAX) ? GY_MAX :
                    (best_q < GY_MIN) ? GY_MIN : best_q;
  assign cnt_ext  = (CNT_W + CNT_BITS)'(count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          case (req_i.action)
            ACT_ADD:   state_d = ST_ADD;
            ACT_CLEAR: state_d = ST_DONE;
            default:   state_d = ST_READ;
          endcase
        end
      end
      ST_ADD: begin
        if (!valid_q[idx_q] || is_last) state_d = ST_DONE;
      end
      ST_READ:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (act_q == ACT_QUERY && covers) state_d = ST_MUL_A;
        else state_d = is_last ? ST_DONE : ST_READ;
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_MUL_C;
      ST_MUL_C: state_d = ST_TEST;
      ST_TEST: begin
        if (num_q >= NUM_W'(prod_q)) state_d = ST_DIV;
        else state_d = is_last ? ST_DONE : ST_READ;
      end
      ST_DIV: begin
        if (dcnt_q == DIV_LAST) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = is_last ? ST_DONE : ST_READ;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req_i.ready         = (state_q == ST_IDLE);
    rsp_o.valid         = out_valid_q;
    rsp_o.hit           = hit_q;
    rsp_o.ground_y      = gy_q;
    rsp_o.table_full    = tfull_q;
    rsp_o.segment_count = cnt_out_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          idx_q   <= '0;
          found_q <= 1'b0;
          full_q  <= 1'b0;
          if (req_fire && req_i.action == ACT_CLEAR) begin
            valid_q <= '0;
            count_q <= '0;
          end
        end
        ST_ADD: begin
          if (!valid_q[idx_q]) begin
            valid_q[idx_q] <= 1'b1;
            count_q        <= count_q + 1'b1;
          end else if (is_last) begin
            full_q <= 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_CHECK: begin
          // Drop every stored copy of the segment
          if (act_q == ACT_DELETE && matches_req) begin
            valid_q[idx_q] <= 1'b0;
            count_q        <= count_q - 1'b1;
          end
          if (!(act_q == ACT_QUERY && covers) && !is_last) idx_q <= idx_q + 1'b1;
        end
        ST_TEST: begin
          if (num_q < NUM_W'(prod_q) && !is_last) idx_q <= idx_q + 1'b1;
        end
        ST_UPDATE: begin
          if (!found_q || cand < best_q) found_q <= 1'b1;
          if (!is_last) idx_q <= idx_q + 1'b1;
        end
        ST_DONE: begin
          if (out_free) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath and table contents
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      act_q <= req_i.action;
      xl_q  <= req_i.seg_x_left;
      yl_q  <= req_i.seg_y_left;
      xr_q  <= req_i.seg_x_right;
      yr_q  <= req_i.seg_y_right;
      px_q  <= req_i.probe_x;
      py_q  <= req_i.probe_y;
    end
    if (state_q == ST_ADD && !valid_q[idx_q]) begin
      mem_q[idx_q] <= {xl_q, yl_q, xr_q, yr_q};
    end
    rd_q <= mem_q[idx_q];

    case (state_q)
      ST_CHECK: begin
        dx_q <= DIF_W'(e_xr) - DIF_W'(e_xl);
        dy_q <= DIF_W'(e_yr) - DIF_W'(e_yl);
        t_q  <= DIF_W'(px_q) - DIF_W'(e_xl);
      end
      ST_MUL_A: prod_q <= prod;
      ST_MUL_B: begin
        prod_q <= prod;
        num_q  <= NUM_W'(prod_q);
      end
      ST_MUL_C: begin
        prod_q <= prod;
        num_q  <= num_q + NUM_W'(prod_q);
      end
      ST_TEST: begin
        // Load the scaled magnitude; the quotient shifts in from the bottom
        neg_q  <= num_q[NUM_W-1];
        dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      ST_DIV: begin
        rem_q  <= step_div ? rem_sub[DIF_W-1:0] : rem_sh[DIF_W-1:0];
        dvd_q  <= {dvd_q[DIV_W-2:0], step_div};
        dcnt_q <= dcnt_q + 1'b1;
      end
      ST_UPDATE: begin
        if (!found_q || cand < best_q) best_q <= cand;
      end
      ST_DONE: begin
        if (out_free) begin
          hit_q     <= (act_q == ACT_QUERY) && found_q;
          gy_q      <= ((act_q == ACT_QUERY) && found_q) ? best_sat[GY_BITS-1:0] : '0;
          tfull_q   <= full_q;
          cnt_out_q <= (cnt_ext > (CNT_W + CNT_BITS)'(127)) ?
                       CNT_BITS'(127) : cnt_ext[CNT_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule
